// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the arm kinematics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is asserted.
`define AFK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define AFK_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFK_ASSERT(lbl, prop, msg)
`define AFK_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/afk_pkg.sv =====
// Types, constants and helper functions of the arm kinematics block.
package afk_pkg;

	// Width of the CORDIC vector components and of the residual angle.
	localparam int CW = 33;
	localparam int ZW = 31;
	localparam int TABLE_LEN = 24;
	localparam int LEN_W = 13;
	localparam int POS_W = 14;
	localparam int ANG_W = 16;
	localparam int SAT_W = 24;

	localparam int LANE_BASE = 0;
	localparam int LANE_LOWER = 1;
	localparam int LANE_UPPER = 2;

	localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;

	localparam logic signed [ANG_W:0] DEG_FULL = 17'sd23040;
	localparam logic signed [ANG_W:0] DEG_HALF = 17'sd11520;
	localparam logic signed [ANG_W:0] DEG_QUARTER = 17'sd5760;

	localparam logic signed [SAT_W-1:0] OUT_MAX = 24'sd8191;
	localparam logic signed [SAT_W-1:0] OUT_MIN = -24'sd8192;

	// Arctangent of 2^-i in units of 2^-22 degree.
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		31'sd188743680, 31'sd111421900, 31'sd58872272, 31'sd29884485,
		31'sd15000234, 31'sd7507429, 31'sd3754631, 31'sd1877430,
		31'sd938729, 31'sd469366, 31'sd234683, 31'sd117342,
		31'sd58671, 31'sd29335, 31'sd14668, 31'sd7334,
		31'sd3667, 31'sd1833, 31'sd917, 31'sd458,
		31'sd229, 31'sd115, 31'sd57, 31'sd29
	};

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_LOWER_LEN,
		REG_UPPER_LEN,
		REG_REACH_OFF,
		REG_HEIGHT_OFF
	} afk_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0] lower_len;
		logic [LEN_W-1:0] upper_len;
		logic [LEN_W-1:0] reach_off;
		logic [LEN_W-1:0] height_off;
	} afk_cfg_t;

	localparam logic [LEN_W-1:0] RST_LOWER_LEN = 13'd2273;
	localparam logic [LEN_W-1:0] RST_UPPER_LEN = 13'd2541;
	localparam logic [LEN_W-1:0] RST_REACH_OFF = 13'd211;
	localparam logic [LEN_W-1:0] RST_HEIGHT_OFF = 13'd1706;

	// One rotator: vector, residual angle and the half-turn fold flag.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
	} afk_rot_t;

	// Three rotators side by side: base, lower arm, upper arm.
	typedef afk_rot_t [2:0] afk_lanes_t;

	// Reduces an angle into -90..90 degree and builds the rotator seed.
	function automatic afk_rot_t seed(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W:0] m1;
		logic signed [ANG_W:0] m2;
		logic neg;
		afk_rot_t r;
		m1 = $signed({a[ANG_W-1], a});
		if (m1 >= DEG_HALF) begin
			m1 = m1 - DEG_FULL;
		end else if (m1 < -DEG_HALF) begin
			m1 = m1 + DEG_FULL;
		end
		m2 = m1;
		neg = 1'b0;
		if (m1 > DEG_QUARTER) begin
			m2 = m1 - DEG_HALF;
			neg = 1'b1;
		end else if (m1 < -DEG_QUARTER) begin
			m2 = m1 + DEG_HALF;
			neg = 1'b1;
		end
		r.x = CORDIC_X0;
		r.y = '0;
		r.z = $signed({m2[13], m2[13:0], 16'b0});
		r.neg = neg;
		return r;
	endfunction

	// Clamps a result to the output field range.
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[POS_W-1:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/arm_forward_kinematics_top.sv =====
// Top level of the three-joint arm forward kinematics block.
//
// Usage: a request on the angle channel carries base, lower and upper joint
// angles in 1/64 degree. Each request produces exactly one request on the
// position channel with x, y and height in 1/16 mm, saturated to 14 bits.
// Both channels move a request at a rising edge where valid is high and
// stall is low. The link lengths and offsets are set through the write
// port (cfg_we, cfg_index, cfg_data) while no request is in flight.
// The pipeline is an angle reduction stage, one cell per CORDIC iteration
// (CORDIC_STAGES capped at 24), and the scaling, summing, base projection
// and output register stages. Throughput is one request per cycle while
// pos_stall is low; the chain of CORDIC cells sets the latency.
// A stall on the position channel holds the output register; every stage
// keeps its own valid bit, so empty stages keep filling and the angle
// channel stalls only once the whole chain is full.
// Reset clears every valid bit and loads the default arm geometry.

`include "assert_macros.svh"

module arm_forward_kinematics_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                angle_valid,
	output logic                                angle_stall,
	input  logic signed [afk_pkg::ANG_W-1:0]    base_angle,
	input  logic signed [afk_pkg::ANG_W-1:0]    lower_angle,
	input  logic signed [afk_pkg::ANG_W-1:0]    upper_angle,
	output logic                                pos_valid,
	input  logic                                pos_stall,
	output logic signed [afk_pkg::POS_W-1:0]    pos_x,
	output logic signed [afk_pkg::POS_W-1:0]    pos_y,
	output logic signed [afk_pkg::POS_W-1:0]    pos_z,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [afk_pkg::LEN_W-1:0]           cfg_data
);

	// Iterations beyond the arctangent table are not run.
	localparam int NS = (CORDIC_STAGES > afk_pkg::TABLE_LEN) ? afk_pkg::TABLE_LEN
		: CORDIC_STAGES;

	afk_pkg::afk_cfg_t cfg_q;

	// Geometry registers. The user must write them only while the pipeline is empty; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_len <= afk_pkg::RST_LOWER_LEN;
			cfg_q.upper_len <= afk_pkg::RST_UPPER_LEN;
			cfg_q.reach_off <= afk_pkg::RST_REACH_OFF;
			cfg_q.height_off <= afk_pkg::RST_HEIGHT_OFF;
		end else if (cfg_we) begin
			case (afk_pkg::afk_reg_t'(cfg_index))
				afk_pkg::REG_LOWER_LEN: cfg_q.lower_len <= cfg_data;
				afk_pkg::REG_UPPER_LEN: cfg_q.upper_len <= cfg_data;
				afk_pkg::REG_REACH_OFF: cfg_q.reach_off <= cfg_data;
				afk_pkg::REG_HEIGHT_OFF: cfg_q.height_off <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Angle reduction stage: wrap to a half turn, fold into +-90 degree and
	// seed the three rotators.
	logic                valid_s1;
	afk_pkg::afk_lanes_t rot_s1;
	logic                ready_s1;

	logic                valid_c [NS+1];
	logic                ready_c [NS+1];
	afk_pkg::afk_lanes_t rot_c [NS+1];

	logic                post_ready;

	assign ready_s1 = !valid_s1 || ready_c[0];
	assign angle_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= angle_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && angle_valid) begin
			rot_s1[afk_pkg::LANE_BASE] <= afk_pkg::seed(base_angle);
			rot_s1[afk_pkg::LANE_LOWER] <= afk_pkg::seed(lower_angle);
			rot_s1[afk_pkg::LANE_UPPER] <= afk_pkg::seed(upper_angle);
		end
	end

	assign valid_c[0] = valid_s1;
	assign rot_c[0] = rot_s1;

	// One cell per CORDIC iteration; cell g shifts by g.
	for (genvar g = 0; g < NS; g++) begin : g_cell
		afk_cordic_cell #(
			.SHIFT(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[g]),
			.in_ready (ready_c[g]),
			.in_rot   (rot_c[g]),
			.out_valid(valid_c[g+1]),
			.out_ready(ready_c[g+1]),
			.out_rot  (rot_c[g+1])
		);
	end

	assign ready_c[NS] = post_ready;

	afk_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[NS]),
		.in_ready (post_ready),
		.in_rot   (rot_c[NS]),
		.cfg      (cfg_q),
		.pos_valid(pos_valid),
		.pos_stall(pos_stall),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z)
	);

	`AFK_ASSERT(a_accept_fills, (angle_valid && !angle_stall) |=> valid_s1, "accepted request not captured")
	`AFK_ASSERT(a_cfg_lower, (cfg_we && cfg_index == afk_pkg::REG_LOWER_LEN) |=> (cfg_q.lower_len == $past(cfg_data)), "lower arm length write lost")
	`AFK_ASSERT_NR(a_reset_idle, !arst_n |=> !pos_valid, "result shown during reset")

endmodule

// ===== rtl/core/afk_cordic_cell.sv =====
// One CORDIC iteration for the three joint rotators, with its own stage register.
`include "assert_macros.svh"

module afk_cordic_cell #(
	parameter int unsigned SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  afk_pkg::afk_lanes_t in_rot,
	output logic                out_valid,
	input  logic                out_ready,
	output afk_pkg::afk_lanes_t out_rot
);

	localparam logic signed [afk_pkg::ZW-1:0] ATAN = afk_pkg::ATAN_TAB[SHIFT];

	logic                valid_s1;
	afk_pkg::afk_lanes_t rot_s1;
	afk_pkg::afk_lanes_t rot_next;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rot_next[k].neg = in_rot[k].neg;
			if (!in_rot[k].z[afk_pkg::ZW-1]) begin
				rot_next[k].x = in_rot[k].x - (in_rot[k].y >>> SHIFT);
				rot_next[k].y = in_rot[k].y + (in_rot[k].x >>> SHIFT);
				rot_next[k].z = in_rot[k].z - ATAN;
			end else begin
				rot_next[k].x = in_rot[k].x + (in_rot[k].y >>> SHIFT);
				rot_next[k].y = in_rot[k].y - (in_rot[k].x >>> SHIFT);
				rot_next[k].z = in_rot[k].z + ATAN;
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rot_s1 <= rot_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_rot = rot_s1;

	`AFK_ASSERT(a_cell_hold, (valid_s1 && !out_ready) |=> (valid_s1 && $stable(rot_s1)), "cell lost a held request")

endmodule

// ===== rtl/core/afk_post.sv =====
// Link scaling, reach and height sums, base projection and output register.
`include "assert_macros.svh"

module afk_post (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  afk_pkg::afk_lanes_t           in_rot,
	input  afk_pkg::afk_cfg_t             cfg,
	output logic                          pos_valid,
	input  logic                          pos_stall,
	output logic signed [afk_pkg::POS_W-1:0] pos_x,
	output logic signed [afk_pkg::POS_W-1:0] pos_y,
	output logic signed [afk_pkg::POS_W-1:0] pos_z
);

	localparam int PW = 47;
	localparam int SW = 49;
	localparam int QW = 32;
	localparam int MW = 64;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	logic signed [afk_pkg::CW-1:0] cos_b, sin_b, cos_l, sin_l, cos_u, sin_u;
	logic signed [afk_pkg::LEN_W:0] lo_len, up_len;

	logic signed [PW-1:0] p_lc_s1, p_uc_s1, p_ls_s1, p_us_s1;
	logic signed [QW-1:0] cb_s1, sb_s1;

	logic signed [SW-1:0] reach_sum, reach_rnd, reach_sh;
	logic signed [SW-1:0] height_sum, height_rnd, height_sh;
	logic signed [QW-1:0] reach_q_s2, cb_s2, sb_s2;
	logic signed [afk_pkg::POS_W-1:0] pz_s2;

	logic signed [MW-1:0] px_s3, py_s3;
	logic signed [afk_pkg::POS_W-1:0] pz_s3;

	logic signed [MW-1:0] px_rnd, py_rnd, px_sh, py_sh;
	logic signed [afk_pkg::POS_W-1:0] pos_x_s4, pos_y_s4, pos_z_s4;

	// Undo the half-turn fold and bring the lengths into signed form.
	always_comb begin
		cos_b = in_rot[afk_pkg::LANE_BASE].neg ? -in_rot[afk_pkg::LANE_BASE].x
			: in_rot[afk_pkg::LANE_BASE].x;
		sin_b = in_rot[afk_pkg::LANE_BASE].neg ? -in_rot[afk_pkg::LANE_BASE].y
			: in_rot[afk_pkg::LANE_BASE].y;
		cos_l = in_rot[afk_pkg::LANE_LOWER].neg ? -in_rot[afk_pkg::LANE_LOWER].x
			: in_rot[afk_pkg::LANE_LOWER].x;
		sin_l = in_rot[afk_pkg::LANE_LOWER].neg ? -in_rot[afk_pkg::LANE_LOWER].y
			: in_rot[afk_pkg::LANE_LOWER].y;
		cos_u = in_rot[afk_pkg::LANE_UPPER].neg ? -in_rot[afk_pkg::LANE_UPPER].x
			: in_rot[afk_pkg::LANE_UPPER].x;
		sin_u = in_rot[afk_pkg::LANE_UPPER].neg ? -in_rot[afk_pkg::LANE_UPPER].y
			: in_rot[afk_pkg::LANE_UPPER].y;
		lo_len = $signed({1'b0, cfg.lower_len});
		up_len = $signed({1'b0, cfg.upper_len});
	end

	// Reach and height at scale 2^30, then rounded.
	always_comb begin
		reach_sum = $signed({{(SW-PW){p_lc_s1[PW-1]}}, p_lc_s1})
			+ $signed({{(SW-PW){p_uc_s1[PW-1]}}, p_uc_s1})
			+ $signed({6'b0, cfg.reach_off, 30'b0});
		height_sum = $signed({{(SW-PW){p_ls_s1[PW-1]}}, p_ls_s1})
			- $signed({{(SW-PW){p_us_s1[PW-1]}}, p_us_s1})
			+ $signed({6'b0, cfg.height_off, 30'b0});
		reach_rnd = reach_sum + (49'sd1 <<< 13);
		reach_sh = reach_rnd >>> 14;
		height_rnd = height_sum + (49'sd1 <<< 29);
		height_sh = height_rnd >>> 30;
	end

	always_comb begin
		px_rnd = px_s3 + (64'sd1 <<< 45);
		py_rnd = py_s3 + (64'sd1 <<< 45);
		px_sh = px_rnd >>> 46;
		py_sh = py_rnd >>> 46;
	end

	assign ready_s4 = !valid_s4 || !pos_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			p_lc_s1 <= PW'(lo_len) * PW'(cos_l);
			p_uc_s1 <= PW'(up_len) * PW'(cos_u);
			p_ls_s1 <= PW'(lo_len) * PW'(sin_l);
			p_us_s1 <= PW'(up_len) * PW'(sin_u);
			cb_s1 <= cos_b[QW-1:0];
			sb_s1 <= sin_b[QW-1:0];
		end
		if (ready_s2 && valid_s1) begin
			reach_q_s2 <= reach_sh[QW-1:0];
			pz_s2 <= afk_pkg::sat_pos(height_sh[afk_pkg::SAT_W-1:0]);
			cb_s2 <= cb_s1;
			sb_s2 <= sb_s1;
		end
		if (ready_s3 && valid_s2) begin
			px_s3 <= MW'(reach_q_s2) * MW'(cb_s2);
			py_s3 <= MW'(reach_q_s2) * MW'(sb_s2);
			pz_s3 <= pz_s2;
		end
		if (ready_s4 && valid_s3) begin
			pos_x_s4 <= afk_pkg::sat_pos(px_sh[afk_pkg::SAT_W-1:0]);
			pos_y_s4 <= afk_pkg::sat_pos(py_sh[afk_pkg::SAT_W-1:0]);
			pos_z_s4 <= pz_s3;
		end
	end

	assign pos_valid = valid_s4;
	assign pos_x = pos_x_s4;
	assign pos_y = pos_y_s4;
	assign pos_z = pos_z_s4;

	`AFK_ASSERT(a_post_advance, (valid_s3 && ready_s4) |=> valid_s4, "result dropped before output register")

endmodule
